// File: hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic timer table: table size,
// command and status codes, and the request and result records.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int MAX_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
    localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_ADD_ZERO = 2'd2,
        KIND_DEL      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_FIRED    = 3'd0,
        STAT_ADDED    = 3'd1,
        STAT_ZERO     = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_DELETED  = 3'd4,
        STAT_NOTFOUND = 3'd5,
        STAT_NONE     = 3'd6
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        timer_id;
        logic [31:0]        period;
        logic signed [31:0] user_value;
        logic [31:0]        time_now;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [15:0]        timer_id;
        logic signed [31:0] user_value;
        logic               last;
    } result_t;

endpackage

// File: hdl/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front
// Accepts requests, decodes the command into a kind and holds decoded
// requests in a short queue for the engine. Unused command codes are dropped.
// ----------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [15:0]        s_timer_id,
    input  logic [31:0]        s_period,
    input  logic signed [31:0] s_user_value,
    input  logic [31:0]        s_time_now,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t                queue_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   fill_reg, fill_next;
    logic                 push;
    logic                 pop;
    item_t                dec_item;

    assign s_ready = (fill_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = queue_mem[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    always_comb begin
        dec_item.kind       = KIND_TICK;
        dec_item.timer_id   = s_timer_id;
        dec_item.period     = s_period;
        dec_item.user_value = s_user_value;
        dec_item.time_now   = s_time_now;
        push                = s_valid && s_ready;
        unique case (s_command)
            CMD_TICK: dec_item.kind = KIND_TICK;
            CMD_ADD: begin
                dec_item.kind = (s_period == '0) ? KIND_ADD_ZERO : KIND_ADD;
            end
            CMD_DEL:  dec_item.kind = KIND_DEL;
            default:  push = 1'b0;
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

// File: hdl/ptt_engine.sv
// ----------------------------------------------------------------------------
// ptt_engine
// Holds the timer table and carries out one request at a time: add in one
// step, tick as a scan with one entry per cycle while results are taken,
// delete as a search followed by a compaction pass.
// ----------------------------------------------------------------------------
module ptt_engine import ptt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_TICK      = 4'b0010,
        S_DEL_FIND  = 4'b0100,
        S_DEL_SHIFT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FIRE_W-1:0]   fires_reg, fires_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [15:0]         pend_id_reg, pend_id_next;
    logic signed [31:0]  pend_word_reg, pend_word_next;
    logic [15:0]         cur_id_reg, cur_id_next;
    logic [31:0]         cur_now_reg, cur_now_next;

    logic [15:0]         ids_mem    [MAX_TIMERS];
    logic [31:0]         period_mem [MAX_TIMERS];
    logic [31:0]         fire_mem   [MAX_TIMERS];
    logic signed [31:0]  word_mem   [MAX_TIMERS];

    logic [CNT_W-1:0]    idx_plus;
    logic [CNT_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    rd_addr;
    logic [15:0]         rd_id;
    logic [31:0]         rd_period;
    logic [31:0]         rd_fire;
    logic signed [31:0]  rd_word;
    logic [31:0]         elapsed;
    logic                due;
    logic                scan_done;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [15:0]         wr_id;
    logic [31:0]         wr_period;
    logic [31:0]         wr_fire;
    logic signed [31:0]  wr_word;

    assign idx_plus  = idx_reg + 1'b1;
    assign rd_idx    = (state_reg == S_DEL_SHIFT) ? idx_plus : idx_reg;
    assign rd_addr   = rd_idx[IDX_W-1:0];
    assign rd_id     = ids_mem[rd_addr];
    assign rd_period = period_mem[rd_addr];
    assign rd_fire   = fire_mem[rd_addr];
    assign rd_word   = word_mem[rd_addr];

    // Wrapping elapsed time since the entry was added or last fired.
    assign elapsed   = cur_now_reg - rd_fire;
    assign due       = (elapsed >= rd_period);
    assign scan_done = (idx_reg == count_reg) || (fires_reg == FIRE_W'(MAX_RESULTS));

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        fires_next      = fires_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_word_next  = pend_word_reg;
        cur_id_next     = cur_id_reg;
        cur_now_next    = cur_now_reg;
        q_pop           = 1'b0;
        res_valid       = 1'b0;
        res.status      = STAT_NONE;
        res.timer_id    = '0;
        res.user_value  = '0;
        res.last        = 1'b1;
        wr_en           = 1'b0;
        wr_addr         = rd_addr;
        wr_id           = rd_id;
        wr_period       = rd_period;
        wr_fire         = rd_fire;
        wr_word         = rd_word;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cur_id_next  = q_item.timer_id;
                    cur_now_next = q_item.time_now;
                    idx_next     = '0;
                    unique case (q_item.kind)
                        KIND_TICK: begin
                            q_pop           = 1'b1;
                            fires_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TICK;
                        end
                        KIND_DEL: begin
                            q_pop      = 1'b1;
                            state_next = S_DEL_FIND;
                        end
                        KIND_ADD_ZERO: begin
                            res_valid    = 1'b1;
                            res.status   = STAT_ZERO;
                            res.timer_id = q_item.timer_id;
                            q_pop        = res_ready;
                        end
                        KIND_ADD: begin
                            res_valid    = 1'b1;
                            res.timer_id = q_item.timer_id;
                            q_pop        = res_ready;
                            if (count_reg >= CNT_W'(MAX_TIMERS)) begin
                                res.status = STAT_FULL;
                            end else begin
                                res.status = STAT_ADDED;
                                wr_en      = res_ready;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_id      = q_item.timer_id;
                                wr_period  = q_item.period;
                                wr_fire    = q_item.time_now;
                                wr_word    = q_item.user_value;
                                if (res_ready) begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_TICK: begin
                if (scan_done) begin
                    res_valid = 1'b1;
                    if (pend_valid_reg) begin
                        res.status     = STAT_FIRED;
                        res.timer_id   = pend_id_reg;
                        res.user_value = pend_word_reg;
                    end
                    if (res_ready) begin
                        state_next = S_IDLE;
                    end
                end else if (!due) begin
                    idx_next = idx_plus;
                end else begin
                    // The held fire result goes out now; it is not the last one.
                    res_valid      = pend_valid_reg;
                    res.status     = STAT_FIRED;
                    res.timer_id   = pend_id_reg;
                    res.user_value = pend_word_reg;
                    res.last       = 1'b0;
                    if (!pend_valid_reg || res_ready) begin
                        wr_en           = 1'b1;
                        wr_fire         = cur_now_reg;
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_id;
                        pend_word_next  = rd_word;
                        fires_next      = fires_reg + 1'b1;
                        idx_next        = idx_plus;
                    end
                end
            end

            S_DEL_FIND: begin
                if (idx_reg == count_reg) begin
                    res_valid    = 1'b1;
                    res.status   = STAT_NOTFOUND;
                    res.timer_id = cur_id_reg;
                    if (res_ready) begin
                        state_next = S_IDLE;
                    end
                end else if (rd_id == cur_id_reg) begin
                    state_next = S_DEL_SHIFT;
                end else begin
                    idx_next = idx_plus;
                end
            end

            S_DEL_SHIFT: begin
                if (idx_plus < count_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[IDX_W-1:0];
                    idx_next = idx_plus;
                end else begin
                    res_valid    = 1'b1;
                    res.status   = STAT_DELETED;
                    res.timer_id = cur_id_reg;
                    if (res_ready) begin
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            fires_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            fires_reg      <= fires_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_id_reg   <= pend_id_next;
        pend_word_reg <= pend_word_next;
        cur_id_reg    <= cur_id_next;
        cur_now_reg   <= cur_now_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ids_mem[wr_addr]    <= wr_id;
            period_mem[wr_addr] <= wr_period;
            fire_mem[wr_addr]   <= wr_fire;
            word_mem[wr_addr]   <= wr_word;
        end
    end

endmodule

// File: hdl/ptt_out_stage.sv
// ----------------------------------------------------------------------------
// ptt_out_stage
// Output register for result items. It takes a new result whenever it is
// empty or its current result is being taken in the same cycle.
// ----------------------------------------------------------------------------
module ptt_out_stage import ptt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    output logic               res_ready,
    input  result_t            res,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [15:0]        m_timer_id_res,
    output logic signed [31:0] m_user_value_res,
    output logic               m_last
);

    logic    valid_reg;
    result_t data_reg;

    assign res_ready        = !valid_reg || m_ready;
    assign m_valid          = valid_reg;
    assign m_status         = data_reg.status;
    assign m_timer_id_res   = data_reg.timer_id;
    assign m_user_value_res = data_reg.user_value;
    assign m_last           = data_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

endmodule

// File: hdl/periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// Ordered table of periodic timers. Requests add, delete or tick; ticks
// return one result per due timer in table order, or one STAT_NONE result if none is due.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Payload
//  -------   ---------  ----------------  -------------------------------------
//  s_        in         s_valid/s_ready   command, timer_id, period,
//                                         user_value, time_now
//  m_        out        m_valid/m_ready   status, timer_id_res,
//                                         user_value_res, last
//
// The engine handles an add directly from idle and walks the table for a tick
// or a delete: its single table read port visits one entry per cycle unless stalled.
// Reset empties the request queue and zeroes the entry count; table contents
// are left as they are, since only entries below the count are ever read.
// A two-entry request queue absorbs requests while the engine works, and the
// engine stalls whenever a result is ready but the output register is full and not draining.
// ----------------------------------------------------------------------------
module periodic_timer_table_top import ptt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [15:0]        s_timer_id,
    input  logic [31:0]        s_period,
    input  logic signed [31:0] s_user_value,
    input  logic [31:0]        s_time_now,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [15:0]        m_timer_id_res,
    output logic signed [31:0] m_user_value_res,
    output logic               m_last
);

    // Decoded requests waiting for the engine.
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;

    // Results from the engine to the output register.
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // The front decodes each request and drops unused command codes, which
    // produce no result.
    ptt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_timer_id   (s_timer_id),
        .s_period     (s_period),
        .s_user_value (s_user_value),
        .s_time_now   (s_time_now),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // The engine owns the table and works on one request at a time.
    ptt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register decouples the engine from the result consumer.
    ptt_out_stage u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_timer_id_res   (m_timer_id_res),
        .m_user_value_res (m_user_value_res),
        .m_last           (m_last)
    );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for periodic_timer_table_top. A predictor of the
// timer table runs next to the block: every accepted request updates the
// predicted table and queues the results that it must cause, and every
// result that leaves the block is checked against the oldest queued one.
// Directed tests cover the table edges, then random traffic with idling and
// a long output stall fill the table and the request queue.
// ----------------------------------------------------------------------------
module tb_top;
    import ptt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command code 3 has no meaning; the block must drop it without a result.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The slowest request is a tick or a delete on a full table; this window
    // covers any internal work.
    localparam int DRAIN_CYCLES = 120;
    // Length of the forced output stall that backs the block up.
    localparam int HOLD_CYCLES  = 400;
    // Worst case per request is a tick with sixteen results, each stalled by
    // the receiver; this limit bounds the whole run.
    localparam int LIMIT_NS     = 6_400_000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic [15:0]        s_timer_id;
    logic [31:0]        s_period;
    logic signed [31:0] s_user_value;
    logic [31:0]        s_time_now;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic [15:0]        m_timer_id_res;
    logic signed [31:0] m_user_value_res;
    logic               m_last;

    // Predicted timer table. Only entries below timer_count are meaningful.
    logic [15:0]        timer_ids     [MAX_TIMERS];
    logic [31:0]        timer_periods [MAX_TIMERS];
    logic [31:0]        timer_stamps  [MAX_TIMERS];
    logic signed [31:0] timer_words   [MAX_TIMERS];
    int                 timer_count;

    // Results still owed by the block, oldest first.
    result_t            pending_results[$];

    // The millisecond clock that the stimulus presents with each request.
    logic [31:0]        now_ms;

    int                 errors;
    int                 requests_sent;
    int                 results_checked;
    int                 fires_seen;
    int                 full_seen;

    // When set, the sender stops idling and the receiver stops stalling.
    bit                 calm;
    // Set by the backpressure test; the receiver clears it after its stall.
    bit                 hold_req;

    periodic_timer_table_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_timer_id       (s_timer_id),
        .s_period         (s_period),
        .s_user_value     (s_user_value),
        .s_time_now       (s_time_now),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_timer_id_res   (m_timer_id_res),
        .m_user_value_res (m_user_value_res),
        .m_last           (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic result_t make_result(status_t st, logic [15:0] id,
                                            logic signed [31:0] word);
        result_t r;
        r.status     = st;
        r.timer_id   = id;
        r.user_value = word;
        r.last       = 1'b0;
        return r;
    endfunction

    // Applies one accepted request to the predicted table and queues the
    // results it causes. Only the final result of a request carries last.
    function automatic void predict_timer_results(logic [1:0] cmd, logic [15:0] id,
                                                  logic [31:0] per,
                                                  logic signed [31:0] word,
                                                  logic [31:0] now);
        result_t batch[$];
        result_t r;
        logic [31:0] age;
        int hit;
        hit = -1;
        case (cmd)
            CMD_TICK: begin
                // Walk in table order; a timer is due once the wrapped age
                // reaches its period, and firing restamps it.
                for (int i = 0; i < timer_count && batch.size() < MAX_RESULTS; i++) begin
                    age = now - timer_stamps[i];
                    if (age >= timer_periods[i]) begin
                        timer_stamps[i] = now;
                        batch = {batch, make_result(STAT_FIRED, timer_ids[i],
                                                    timer_words[i])};
                    end
                end
                if (batch.size() == 0) begin
                    batch = {batch, make_result(STAT_NONE, 16'h0000, 32'sd0)};
                end
            end
            CMD_ADD: begin
                // A zero period is rejected before the table size is looked at.
                if (per == 32'd0) begin
                    batch = {batch, make_result(STAT_ZERO, id, 32'sd0)};
                end else if (timer_count >= MAX_TIMERS) begin
                    batch = {batch, make_result(STAT_FULL, id, 32'sd0)};
                end else begin
                    timer_ids[timer_count]     = id;
                    timer_periods[timer_count] = per;
                    timer_stamps[timer_count]  = now;
                    timer_words[timer_count]   = word;
                    timer_count++;
                    batch = {batch, make_result(STAT_ADDED, id, 32'sd0)};
                end
            end
            CMD_DEL: begin
                for (int i = 0; i < timer_count && hit < 0; i++) begin
                    if (timer_ids[i] == id) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    // Later entries move up one place to close the gap.
                    for (int i = hit; i + 1 < timer_count; i++) begin
                        timer_ids[i]     = timer_ids[i + 1];
                        timer_periods[i] = timer_periods[i + 1];
                        timer_stamps[i]  = timer_stamps[i + 1];
                        timer_words[i]   = timer_words[i + 1];
                    end
                    timer_count--;
                    batch = {batch, make_result(STAT_DELETED, id, 32'sd0)};
                end else begin
                    batch = {batch, make_result(STAT_NOTFOUND, id, 32'sd0)};
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < batch.size(); k++) begin
            r      = batch[k];
            r.last = (k == batch.size() - 1);
            pending_results = {pending_results, r};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge where it is taken. The caller
    // is always at a rising edge, and valid is only lowered outside this task,
    // so back-to-back requests keep valid high without a glitch.
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] id,
                                input logic [31:0] per, input logic signed [31:0] word,
                                input logic [31:0] now);
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_timer_id   <= id;
        s_period     <= per;
        s_user_value <= word;
        s_time_now   <= now;
        do @(posedge aclk); while (!s_ready);
        predict_timer_results(cmd, id, per, word, now);
        requests_sent++;
    endtask

    // Sometimes idles for a random gap before the next request, unless calm.
    task automatic pause_sender();
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic offer(input logic [1:0] cmd, input logic [15:0] id,
                         input logic [31:0] per, input logic signed [31:0] word);
        pause_sender();
        send_request(cmd, id, per, word, now_ms);
    endtask

    // Mostly identifiers that are in the table or from a small pool, so that
    // deletes hit and duplicates occur; now and then any 16-bit value.
    function automatic logic [15:0] pick_id();
        int roll;
        roll = $urandom_range(0, 9);
        if (timer_count > 0 && roll < 6) begin
            return timer_ids[$urandom_range(0, timer_count - 1)];
        end else if (roll < 8) begin
            return 16'($urandom_range(0, 7));
        end
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold on request.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // The sender keeps offering requests during this hold, so the
                // output register and the request queue both fill up.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d id %h value %h last %b",
                         $time, m_status, m_timer_id_res, m_user_value_res, m_last);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_timer_id_res !== want.timer_id) begin
                    $display("%0t: timer id mismatch: expected %h, actual %h",
                             $time, want.timer_id, m_timer_id_res);
                    errors++;
                end
                if (m_user_value_res !== want.user_value) begin
                    $display("%0t: user value mismatch: expected %h, actual %h",
                             $time, want.user_value, m_user_value_res);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last flag mismatch: expected %b, actual %b",
                             $time, want.last, m_last);
                    errors++;
                end
                if (want.status == STAT_FIRED) fires_seen++;
                if (want.status == STAT_FULL) full_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // An empty table: a tick finds nothing due, the unused command code is
    // dropped silently, and a delete finds no match.
    task automatic test_empty_table();
        now_ms = 32'd100;
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
        offer(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, -32'sd1);
        now_ms = 32'hFFFF_FFFF;
        offer(CMD_DEL, 16'h1234, 32'd5, 32'sd5);
    endtask

    // Zero period, extreme identifiers, periods and user words, and a
    // duplicate identifier, all stamped at the top of the time range.
    task automatic test_add_cases();
        now_ms = 32'hFFFF_FFFF;
        offer(CMD_ADD, 16'hFFFF, 32'd0, 32'sh7FFF_FFFF);
        offer(CMD_ADD, 16'h0000, 32'hFFFF_FFFF, 32'sh8000_0000);
        offer(CMD_ADD, 16'hFFFF, 32'd1, 32'sh7FFF_FFFF);
        offer(CMD_ADD, 16'hFFFF, 32'd3, -32'sd1);
        offer(CMD_ADD, 16'h5A5A, 32'd2, 32'sd0);
    endtask

    // Time wraps past zero; the age is taken modulo 2^32. The last tick sees
    // an age of all ones, which makes even the largest period due.
    task automatic test_tick_wrap();
        now_ms = 32'd0;
        offer(CMD_TICK, 16'hA5A5, 32'h5555_5555, 32'shAAAA_AAAA);
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
        now_ms = 32'd2;
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
        now_ms = 32'hFFFF_FFFE;
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
    endtask

    // Delete takes the first of two equal identifiers and the table closes
    // up; the tick in between shows the order that remains.
    task automatic test_delete_cases();
        offer(CMD_DEL, 16'hFFFF, 32'd0, 32'sd0);
        offer(CMD_DEL, 16'h1234, 32'd0, 32'sd0);
        now_ms = now_ms + 32'd5;
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
        offer(CMD_DEL, 16'h5A5A, 32'd0, 32'sd0);
        offer(CMD_DEL, 16'h0000, 32'd0, 32'sd0);
        offer(CMD_DEL, 16'hFFFF, 32'd0, 32'sd0);
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
    endtask

    // Fills the table, pushes one more add and a zero-period add against the
    // full table, fires all sixteen timers in one tick, then empties it.
    task automatic test_full_table();
        while (timer_count < MAX_TIMERS) begin
            now_ms = now_ms + 32'($urandom_range(0, 3));
            offer(CMD_ADD, pick_id(), 32'($urandom_range(1, 40)), $urandom);
        end
        offer(CMD_ADD, 16'($urandom), 32'd7, $urandom);
        offer(CMD_ADD, 16'($urandom), 32'd0, $urandom);
        now_ms = now_ms + 32'd1000;
        offer(CMD_TICK, 16'h0000, 32'd0, 32'sd0);
        while (timer_count > 0) begin
            offer(CMD_DEL, timer_ids[$urandom_range(0, timer_count - 1)], 32'd0, 32'sd0);
        end
    endtask

    // Mixed traffic. Most requests are ticks, adds and deletes aimed at the
    // live table with time moving forward in small steps, so timers keep
    // falling due; time jumps, huge periods, zero periods and the unused
    // code are mixed in. Dropped requests are not counted.
    task automatic test_random_traffic(input int count);
        int sent;
        int pick;
        logic [1:0] cmd;
        logic [31:0] per;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0) begin
                now_ms = $urandom;
            end else begin
                now_ms = now_ms + 32'($urandom_range(0, 12));
            end
            per = 32'($urandom_range(1, 40));
            if ($urandom_range(0, 9) == 0) per = $urandom;
            if ($urandom_range(0, 19) == 0) per = 32'd0;
            if (pick < 40) begin
                cmd = CMD_TICK;
            end else if (pick < 70) begin
                cmd = CMD_ADD;
            end else if (pick < 95) begin
                cmd = CMD_DEL;
            end else begin
                cmd = CMD_UNUSED;
            end
            offer(cmd, pick_id(), per, $urandom);
            if (cmd != CMD_UNUSED) sent++;
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // without gaps; ticks with many due timers back the block up until it
    // drops s_ready.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 0 && timer_count < MAX_TIMERS) begin
                send_request(CMD_ADD, pick_id(), 32'($urandom_range(1, 20)), $urandom, now_ms);
            end else begin
                now_ms = now_ms + 32'd25;
                send_request(CMD_TICK, 16'($urandom), $urandom, $urandom, now_ms);
            end
        end
        // The last request has been taken, so valid drops while waiting.
        while (hold_req) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        errors          = 0;
        requests_sent   = 0;
        results_checked = 0;
        fires_seen      = 0;
        full_seen       = 0;
        timer_count     = 0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        now_ms          = 32'd0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_TICK;
        s_timer_id      = 16'h0000;
        s_period        = 32'd0;
        s_user_value    = 32'sd0;
        s_time_now      = 32'd0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_add_cases();
        test_tick_wrap();
        test_delete_cases();
        test_full_table();
        test_random_traffic(150);
        test_backpressure();
        test_random_traffic(130);

        // Final stretch with no idling on either side.
        calm = 1'b1;
        test_random_traffic(60);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        // Any stray result would show up in this window.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests; checked %0d results, %0d of them timer fires.",
                 requests_sent, results_checked, fires_seen);
        $display("Table-full rejections seen: %0d; mismatches: %0d.", full_seen, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("%0t: run timed out with %0d results outstanding",
                 $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
